// ----- hdl/dcb_pkg.sv -----
package dcb_pkg;

  localparam int NUM_CELLS = 65536;
  localparam int MAX_MAPS = 4;
  localparam int MAX_CELL_POINTS = 32;
  localparam int CELL_W = $clog2(NUM_CELLS);
  localparam int SLOT_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
  localparam int ADDR_W = SLOT_W + CELL_W;
  localparam int CNT_W = 6;
  localparam int POS_W = 5;

  localparam logic [1:0] REG_DURATION = 2'd0;
  localparam logic [1:0] REG_MAX_MAPS = 2'd1;
  localparam logic [1:0] REG_MAX_POINTS = 2'd2;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_CREATED = 3'd3;
  localparam logic [2:0] ST_RECYCLED = 3'd4;
  localparam logic [2:0] ST_KEPT = 3'd5;

  typedef struct packed {
    logic [31:0] stamp;
    logic [CNT_W-1:0] count;
    logic [15:0] max_depth;
    logic [15:0] min_depth;
    logic [POS_W-1:0] max_pos;
    logic [POS_W-1:0] min_pos;
    logic [15:0] smin;
    logic [15:0] smax;
    logic seen;
  } cell_rec_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] slot;
    logic [31:0] map_number;
    logic [4:0] index_in_cell;
    logic [5:0] cell_fill;
  } result_t;

endpackage

// ----- hdl/dcb_cell_ram.sv -----
module dcb_cell_ram
  import dcb_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_rec_t wdata,
  input  logic [ADDR_W-1:0] raddr,
  output cell_rec_t rdata
);

  cell_rec_t mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dcb_clear.sv -----
module dcb_clear
  import dcb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  output logic busy,
  output logic [ADDR_W-1:0] addr
);

  logic [ADDR_W:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (!cnt[ADDR_W]) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign busy = !cnt[ADDR_W];
  assign addr = cnt[ADDR_W-1:0];

endmodule

// ----- hdl/depth_cell_binning_with_map_rotation.sv -----
// channel | signals                                           | dir
// in      | in_valid, in_stall, kind..is_static               | sink
// out     | out_valid, out_stall, status..cell_fill           | source
// Every item passes through accept (cell memory read issued), result select and
// write back, then load of the output register. The cell memory read is registered.
// After reset a clearing pass writes every cell record, during which no item is
// accepted. No item is accepted while a result is stalled in the output register;
// a stalled output holds the finished result back.
module depth_cell_binning_with_map_rotation
  import dcb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic kind,
  input  logic [47:0] timestamp_us,
  input  logic signed [17:0] cell_req,
  input  logic [15:0] depth,
  input  logic is_static,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [1:0] slot,
  output logic [31:0] map_number,
  output logic [4:0] index_in_cell,
  output logic [5:0] cell_fill
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  logic [31:0] duration;
  logic [2:0] max_maps;
  logic [5:0] max_points;
  logic [31:0] map_id [MAX_MAPS];
  logic [SLOT_W-1:0] newest;
  logic [SLOT_W:0] used;
  logic [47:0] newest_time;
  logic [31:0] counter;
  logic i_kind, i_static;
  logic [47:0] i_ts;
  logic signed [17:0] i_cell;
  logic [15:0] i_depth;
  logic [ADDR_W-1:0] i_addr;
  logic [ADDR_W-1:0] raddr;
  cell_rec_t rd, wr;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic clr_busy;
  logic [ADDR_W-1:0] clr_addr;
  result_t res, res_next, pt_res;
  cell_rec_t upd;
  logic upd_we;
  logic frame_due;
  logic [SLOT_W-1:0] new_slot;

  dcb_clear u_clear (.clk(clk), .rst(rst), .busy(clr_busy), .addr(clr_addr));

  dcb_cell_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wr),
                      .raddr(raddr), .rdata(rd));

  assign in_stall = clr_busy || (state != S_IDLE) || (out_valid && out_stall);
  wire in_fire = in_valid && !in_stall;

  assign raddr = (state == S_IDLE) ? {newest, cell_req[CELL_W-1:0]} : i_addr;

  always_comb begin
    we = clr_busy || upd_we;
    waddr = clr_busy ? clr_addr : i_addr;
    wr = clr_busy ? '0 : upd;
  end

  // limits
  logic [SLOT_W:0] limit;
  logic [5:0] cap;
  always_comb begin
    if (max_maps == 3'd0) limit = (SLOT_W+1)'(1);
    else if (32'(max_maps) > MAX_MAPS) limit = (SLOT_W+1)'(MAX_MAPS);
    else limit = (SLOT_W+1)'(max_maps);
    cap = (32'(max_points) > MAX_CELL_POINTS) ? 6'(MAX_CELL_POINTS) : max_points;
  end

  // oldest slot
  logic [SLOT_W-1:0] oldest;
  always_comb begin
    logic [31:0] best_age, age;
    oldest = '0;
    best_age = '0;
    for (int s = 0; s < MAX_MAPS; s++) begin
      age = counter - map_id[s];
      if ((SLOT_W+1)'(s) < used && (s == 0 || age > best_age)) begin
        oldest = SLOT_W'(s);
        best_age = age;
      end
    end
  end

  logic cell_ok;
  assign cell_ok = !i_cell[17] && ({1'b0, i_cell[16:0]} < 18'(NUM_CELLS));

  // point update
  always_comb begin
    logic cur;
    logic [CNT_W-1:0] cnt;
    logic first;
    upd = rd;
    upd_we = 1'b0;
    pt_res = '0;
    pt_res.slot = 2'(newest);
    pt_res.map_number = map_id[newest];
    cur = (rd.stamp == map_id[newest]);
    cnt = cur ? rd.count : '0;
    first = (cnt == '0);
    if (cnt >= cap) begin
      pt_res.status = ST_FULL;
      pt_res.cell_fill = cnt;
    end else begin
      upd_we = (state == S_READ) && i_kind && (used != '0) && cell_ok;
      upd.stamp = map_id[newest];
      if (!cur) upd.seen = 1'b0;
      upd.count = cnt + 1'b1;
      if (first || i_depth > rd.max_depth) begin
        upd.max_depth = i_depth;
        upd.max_pos = POS_W'(cnt);
      end
      if (first || i_depth < rd.min_depth) begin
        upd.min_depth = i_depth;
        upd.min_pos = POS_W'(cnt);
      end
      if (i_static) begin
        if (!upd.seen) begin
          upd.smin = i_depth;
          upd.smax = i_depth;
          upd.seen = 1'b1;
        end else begin
          if (i_depth < rd.smin) upd.smin = i_depth;
          if (i_depth > rd.smax) upd.smax = i_depth;
        end
      end
      pt_res.status = ST_ADDED;
      pt_res.index_in_cell = 5'(cnt);
      pt_res.cell_fill = cnt + 1'b1;
    end
  end

  // result select
  always_comb begin
    frame_due = (used == '0) ||
                (i_ts >= newest_time && (i_ts - newest_time) >= {16'd0, duration});
    new_slot = (used >= limit) ? oldest : used[SLOT_W-1:0];
    res_next = '0;
    if (!i_kind) begin
      if (!frame_due) begin
        res_next.status = ST_KEPT;
        res_next.slot = 2'(newest);
        res_next.map_number = map_id[newest];
      end else begin
        res_next.status = (used >= limit) ? ST_RECYCLED : ST_CREATED;
        res_next.slot = 2'(new_slot);
        res_next.map_number = counter + 1'b1;
      end
    end else if (used == '0) begin
      res_next.status = ST_INVALID;
    end else if (!cell_ok) begin
      res_next.status = ST_INVALID;
      res_next.slot = 2'(newest);
      res_next.map_number = map_id[newest];
    end else begin
      res_next = pt_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      duration <= 32'd300000;
      max_maps <= 3'd4;
      max_points <= 6'd32;
      for (int s = 0; s < MAX_MAPS; s++) map_id[s] <= '0;
      newest <= '0;
      used <= '0;
      newest_time <= '0;
      counter <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DURATION: duration <= cfg_data;
          REG_MAX_MAPS: max_maps <= cfg_data[2:0];
          REG_MAX_POINTS: max_points <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            i_kind <= kind;
            i_ts <= timestamp_us;
            i_cell <= cell_req;
            i_depth <= depth;
            i_static <= is_static;
            i_addr <= raddr;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
          res <= res_next;
          if (!i_kind && frame_due) begin
            if (used < limit) used <= used + 1'b1;
            counter <= counter + 1'b1;
            map_id[new_slot] <= counter + 1'b1;
            newest <= new_slot;
            newest_time <= i_ts;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  result_t ob;
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) ob <= res;
  end

  assign status = ob.status;
  assign slot = ob.slot;
  assign map_number = ob.map_number;
  assign index_in_cell = ob.index_in_cell;
  assign cell_fill = ob.cell_fill;

endmodule

// ----- hdl/dcb_checker.sv -----
module dcb_checker
  import dcb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [2:0] status,
  input logic [4:0] index_in_cell,
  input logic [5:0] cell_fill
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  a_added: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ADDED |-> cell_fill == 6'(index_in_cell) + 6'd1)
    else $error("fill mismatch");

  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_CREATED || status == ST_RECYCLED || status == ST_KEPT)
      |-> cell_fill == '0)
    else $error("frame fill nonzero");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("beat accepted while busy");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule

bind depth_cell_binning_with_map_rotation dcb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .index_in_cell(index_in_cell), .cell_fill(cell_fill)
);
